/* rtl/bba_pkg.sv */
// Shared types, constants and command/status bundles of the buddy block allocator.
package bba_pkg;

  localparam int MAX_ORDER   = 10;
  localparam int BLOCK_BYTES = 8;
  localparam int BLK_SH      = $clog2(BLOCK_BYTES);
  localparam int NODE_COUNT  = (2 << MAX_ORDER) - 1;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LV_W        = $clog2(MAX_ORDER + 1);
  localparam int DEPTH_W     = $clog2(MAX_ORDER + 1);
  localparam int OFF_W       = (MAX_ORDER > 0) ? MAX_ORDER : 1;
  localparam int ADDR_W      = 48;
  localparam int BYTES_W     = 24;
  localparam int Q_W         = BYTES_W - BLK_SH;
  localparam int K_W         = $clog2(Q_W + 1);
  localparam int ORDER_W     = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ORDER  = 2'd1;
  localparam logic [ORDER_W-1:0]   TOTAL_ORDER_RST  = 4'd10;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_SPLIT  = 2'd2
  } node_st_t;

  // What remains to be tried at a split node on the search path.
  typedef enum logic [1:0] {
    MD_BOTH_FIRST  = 2'd0,
    MD_BOTH_SECOND = 2'd1,
    MD_ONLY_LEFT   = 2'd2,
    MD_ONLY_RIGHT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    NAV_HOLD   = 2'd0,
    NAV_LEFT   = 2'd1,
    NAV_RIGHT  = 2'd2,
    NAV_PARENT = 2'd3
  } nav_t;

  typedef enum logic [2:0] {
    AS_NODE  = 3'd0,
    AS_LEFT  = 3'd1,
    AS_RIGHT = 3'd2,
    AS_SIB   = 3'd3,
    AS_CLEAR = 3'd4
  } addr_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_START, S_A_VISIT, S_A_CHK, S_A_RDL, S_A_RDR,
    S_A_POP, S_A_RESUME, S_A_CLAIM, S_F_VISIT, S_F_CHK, S_F_UP, S_F_SIB,
    S_F_CLR, S_DONE
  } state_t;

  typedef struct packed {
    logic      load;
    nav_t      nav;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    node_st_t  wr_val;
    logic      stk_wr;
    mode_t     stk_val;
    logic      latch_left;
    logic      res_set;
    logic      res_ok;
    logic      res_grant;
    logic      out_push;
    logic      clr_step;
  } cmd_t;

  typedef struct packed {
    logic     is_free;
    logic     size_zero;
    logic     k_too_big;
    logic     lv_lt_k;
    logic     lv_gt_k;
    logic     lv_zero;
    logic     d_zero;
    logic     addr_match;
    logic     go_right;
    logic     clr_last;
    node_st_t rd_st;
    node_st_t left_st;
    mode_t    mode;
  } sts_t;

endpackage

/* rtl/bba_dp.sv */
// Datapath of the buddy allocator: node memory, walk registers, search stack and result.
module bba_dp import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_kind,
  input  logic [BYTES_W-1:0]   in_bytes,
  input  logic [ADDR_W-1:0]    in_addr,
  output logic [ADDR_W-1:0]    out_addr,
  output logic                 out_ok
);

  logic [1:0]            mem [NODE_COUNT];
  logic [1:0]            rdata_r;
  logic [NODE_W-1:0]     maddr;

  logic [ADDR_W-1:0]     rb_r;
  logic [ORDER_W-1:0]    order_r;
  logic [LV_W-1:0]       root_lv;

  logic                  kind_r;
  logic                  zero_r;
  logic [K_W-1:0]        k_r;
  logic [K_W-1:0]        k_nxt;
  logic [ADDR_W-1:0]     rel_r;
  logic [NODE_W-1:0]     node_r;
  logic [LV_W-1:0]       lv_r;
  logic [OFF_W-1:0]      off_r;
  logic [DEPTH_W-1:0]    d_r;
  mode_t                 stk_r [MAX_ORDER+1];
  node_st_t              left_r;
  logic [NODE_W-1:0]     clr_r;
  logic [ADDR_W-1:0]     res_addr_r;
  logic                  res_ok_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic                  out_ok_r;

  logic [BYTES_W-1:0]    bm1;
  logic [Q_W-1:0]        q;
  logic [ADDR_W-1:0]     na;
  logic [ADDR_W-1:0]     brk;
  logic [ADDR_W:0]       rb_sum;

  assign root_lv = (order_r > ORDER_W'(MAX_ORDER)) ? LV_W'(MAX_ORDER) : LV_W'(order_r);

  // Bit length of (bytes-1)/BLOCK_BYTES gives the block order of the request.
  assign bm1 = in_bytes - BYTES_W'(1);
  assign q   = bm1[BYTES_W-1:BLK_SH];
  always_comb begin
    k_nxt = '0;
    for (int j = 0; j < Q_W; j++) begin
      if (q[j]) k_nxt = K_W'(j + 1);
    end
  end

  assign na  = rb_r + (ADDR_W'(off_r) << BLK_SH);
  assign brk = na + (ADDR_W'(1) << (lv_r + LV_W'(BLK_SH - 1)));
  assign rb_sum = {1'b0, cfg_data} + (ADDR_W+1)'(BLOCK_BYTES - 1);

  always_comb begin
    case (cmd.addr_sel)
      AS_LEFT:  maddr = {node_r[NODE_W-2:0], 1'b1};
      AS_RIGHT: maddr = {node_r[NODE_W-2:0], 1'b0} + NODE_W'(2);
      AS_SIB:   maddr = node_r[0] ? node_r + NODE_W'(1) : node_r - NODE_W'(1);
      AS_CLEAR: maddr = clr_r;
      default:  maddr = node_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[maddr] <= cmd.wr_val;
    if (cmd.mem_rd) rdata_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r     <= '0;
      order_r  <= TOTAL_ORDER_RST;
      clr_r    <= '0;
      out_ok_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_BASE_ADDRESS) begin
        rb_r <= {rb_sum[ADDR_W-1:BLK_SH], BLK_SH'(0)};
      end
      if (cfg_we && cfg_index == REG_TOTAL_ORDER) order_r <= cfg_data[ORDER_W-1:0];
      if (cfg_we) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= clr_r + NODE_W'(1);
      if (cmd.out_push) out_ok_r <= res_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      zero_r <= (in_bytes == '0);
      k_r    <= k_nxt;
      rel_r  <= in_addr;
      node_r <= '0;
      lv_r   <= root_lv;
      off_r  <= '0;
      d_r    <= '0;
    end else begin
      case (cmd.nav)
        NAV_LEFT: begin
          node_r <= {node_r[NODE_W-2:0], 1'b1};
          lv_r   <= lv_r - LV_W'(1);
          d_r    <= d_r + DEPTH_W'(1);
        end
        NAV_RIGHT: begin
          node_r <= {node_r[NODE_W-2:0], 1'b0} + NODE_W'(2);
          off_r  <= off_r + (OFF_W'(1) << (lv_r - LV_W'(1)));
          lv_r   <= lv_r - LV_W'(1);
          d_r    <= d_r + DEPTH_W'(1);
        end
        NAV_PARENT: begin
          node_r <= (node_r - NODE_W'(1)) >> 1;
          if (!node_r[0]) off_r <= off_r - (OFF_W'(1) << lv_r);
          lv_r   <= lv_r + LV_W'(1);
          d_r    <= d_r - DEPTH_W'(1);
        end
        default: ;
      endcase
    end
    if (cmd.stk_wr) stk_r[d_r] <= cmd.stk_val;
    if (cmd.latch_left) left_r <= node_st_t'(rdata_r);
    if (cmd.res_set) begin
      res_ok_r   <= cmd.res_ok;
      res_addr_r <= cmd.res_grant ? na : '0;
    end
    if (cmd.out_push) out_addr_r <= res_addr_r;
  end

  assign sts.is_free    = kind_r;
  assign sts.size_zero  = zero_r;
  assign sts.k_too_big  = k_r > K_W'(root_lv);
  assign sts.lv_lt_k    = K_W'(lv_r) < k_r;
  assign sts.lv_gt_k    = K_W'(lv_r) > k_r;
  assign sts.lv_zero    = (lv_r == '0);
  assign sts.d_zero     = (d_r == '0);
  assign sts.addr_match = (na == rel_r);
  assign sts.go_right   = (rel_r >= brk);
  assign sts.clr_last   = (clr_r == NODE_W'(NODE_COUNT - 1));
  assign sts.rd_st      = node_st_t'(rdata_r);
  assign sts.left_st    = left_r;
  assign sts.mode       = stk_r[d_r];

  assign out_addr = out_addr_r;
  assign out_ok   = out_ok_r;

endmodule

/* rtl/bba_ctrl.sv */
// Controller state machine of the buddy allocator: sequences the tree walks.
module bba_ctrl import bba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_clear,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= cfg_clear ? S_CLEAR : state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '{load: 1'b0, nav: NAV_HOLD, mem_rd: 1'b0, mem_wr: 1'b0, addr_sel: AS_NODE,
            wr_val: ST_ABSENT, stk_wr: 1'b0, stk_val: MD_BOTH_FIRST, latch_left: 1'b0,
            res_set: 1'b0, res_ok: 1'b0, res_grant: 1'b0, out_push: 1'b0,
            clr_step: 1'b0};
    unique case (state_r)
      S_CLEAR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AS_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_A_START;
        end
      end
      S_A_START: begin
        if (sts.is_free) begin
          state_nxt = S_F_VISIT;
        end else if (sts.size_zero || sts.k_too_big) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_A_VISIT;
        end
      end
      S_A_VISIT: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.lv_lt_k) begin
          state_nxt = S_A_POP;
        end else if (sts.rd_st == ST_ABSENT) begin
          state_nxt = S_A_CLAIM;
        end else if (sts.rd_st != ST_SPLIT || sts.lv_zero) begin
          state_nxt = S_A_POP;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = AS_LEFT;
          state_nxt    = S_A_RDL;
        end
      end
      S_A_RDL: begin
        cmd.latch_left = 1'b1;
        cmd.mem_rd     = 1'b1;
        cmd.addr_sel   = AS_RIGHT;
        state_nxt      = S_A_RDR;
      end
      S_A_RDR: begin
        cmd.stk_wr = 1'b1;
        if (sts.left_st != ST_ABSENT) begin
          cmd.stk_val = (sts.rd_st != ST_ABSENT) ? MD_BOTH_FIRST : MD_ONLY_LEFT;
          cmd.nav     = NAV_LEFT;
          state_nxt   = S_A_VISIT;
        end else if (sts.rd_st != ST_ABSENT) begin
          cmd.stk_val = MD_ONLY_RIGHT;
          cmd.nav     = NAV_RIGHT;
          state_nxt   = S_A_VISIT;
        end else begin
          state_nxt = S_A_POP;
        end
      end
      S_A_POP: begin
        if (sts.d_zero) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.nav   = NAV_PARENT;
          state_nxt = S_A_RESUME;
        end
      end
      S_A_RESUME: begin
        case (sts.mode)
          MD_BOTH_FIRST: begin
            cmd.stk_wr  = 1'b1;
            cmd.stk_val = MD_BOTH_SECOND;
            cmd.nav     = NAV_RIGHT;
            state_nxt   = S_A_VISIT;
          end
          MD_ONLY_LEFT: begin
            if (sts.lv_gt_k) begin
              cmd.nav   = NAV_RIGHT;
              state_nxt = S_A_CLAIM;
            end else begin
              state_nxt = S_A_POP;
            end
          end
          MD_ONLY_RIGHT: begin
            if (sts.lv_gt_k) begin
              cmd.nav   = NAV_LEFT;
              state_nxt = S_A_CLAIM;
            end else begin
              state_nxt = S_A_POP;
            end
          end
          default: state_nxt = S_A_POP;
        endcase
      end
      S_A_CLAIM: begin
        cmd.mem_wr = 1'b1;
        if (sts.lv_gt_k) begin
          cmd.wr_val = ST_SPLIT;
          cmd.nav    = NAV_LEFT;
        end else begin
          cmd.wr_val    = ST_ALLOC;
          cmd.res_set   = 1'b1;
          cmd.res_ok    = 1'b1;
          cmd.res_grant = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_F_VISIT: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts.rd_st == ST_ABSENT) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else if (sts.rd_st != ST_SPLIT) begin
          if (sts.addr_match) begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_F_UP;
          end else begin
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
        end else if (sts.lv_zero) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.nav   = sts.go_right ? NAV_RIGHT : NAV_LEFT;
          state_nxt = S_F_VISIT;
        end
      end
      S_F_UP: begin
        if (sts.d_zero) begin
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = AS_SIB;
          state_nxt    = S_F_SIB;
        end
      end
      S_F_SIB: begin
        if (sts.rd_st == ST_ABSENT) begin
          cmd.nav   = NAV_PARENT;
          state_nxt = S_F_CLR;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_F_CLR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = S_F_UP;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid_nxt = cmd.out_push || (out_valid_r && !out_ready);

endmodule

/* rtl/buddy_block_allocator_core.sv */
// Top level of the buddy block allocator: ports, controller and datapath.
// An allocate reads each node it visits, reads both children of a split node, backs up
// one level at a time when a subtree fails and claims the chosen block level by level; an
// item is taken at the start and its result handed off at the end. A free walks down to the
// block and merges free buddies level by level on the way up. One item walks at a time; the
// next is taken while a result waits. Reset and every write to a defined register run a
// clearing pass over every node of the tree.
module buddy_block_allocator_core import bba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // request_bytes[23:0], release_address[71:24]
  input  logic                 in_tuser,   // kind (0 allocate, 1 free)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ADDR_W-1:0]    out_tdata,  // granted_address[47:0]
  output logic                 out_tuser,  // success
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;
  logic cfg_clear;

  // Configuration is always taken; a transfer to a defined register empties the tree.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_we && (cfg_index == REG_BASE_ADDRESS ||
                                cfg_index == REG_TOTAL_ORDER);

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (cfg_clear),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_clear),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (in_tuser),
    .in_bytes  (in_tdata[BYTES_W-1:0]),
    .in_addr   (in_tdata[BYTES_W+ADDR_W-1:BYTES_W]),
    .out_addr  (out_tdata),
    .out_ok    (out_tuser)
  );

  // An accepted item keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("input reopened after accept");

  // A failed or free result never carries an address unless it is a granted allocate.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0) else $error("failure with address");

  // A write to a defined register starts the clearing pass, which closes the input.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> !in_tready) else $error("input open after configuration write");

  // Leaving reset always begins with the clearing pass.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !in_tready) else $error("input open right after reset");

endmodule
